>>> rtl/mse_pkg.sv
// Package for the merge sort engine.
// Holds the data width and the sequencer state type; no dependencies.
package mse_pkg;

    // Width of one element.
    localparam int DATA_W = 32;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PASS,
        ST_RUN,
        ST_MERGE,
        ST_OUT
    } mse_state_t;

endpackage

>>> rtl/mse_bank.sv
// Element bank: one synchronous memory with one write port and two read ports.
// Read data is registered, so it appears in the cycle after the address. Uses mse_pkg.
module mse_bank
    import mse_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [AW-1:0]     raddr_a,
    input  logic [AW-1:0]     raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Two registered read ports.
    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem[raddr_a];
        rd_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rd_a_reg;
    assign rdata_b = rd_b_reg;

endmodule

>>> rtl/merge_sort_engine_unit.sv
// Top level of the merge sort engine: load sequencer, merge sequencer and
// the two element banks. Uses mse_pkg and mse_bank.
//
// Usage: elements enter on value/last; a request is taken on a rising edge
// with start high and busy low. Elements are stored one per request until a
// request with last set arrives; that element is stored too (unless the store
// already holds MAX_ELEMS elements, in which case it is dropped) and busy
// rises while the batch is sorted ascending, equal keys keeping load order.
// Sorting runs bottom-up merge passes that ping-pong between the two banks.
// Each pass opens in the pass state, sets up each run pair in the run state,
// merges the pair in the merge state, closes in the run state; the pass state
// that finds runs as wide as the batch enters readout. A batch of n elements
// takes ceil(log2 n) passes. Both heads are read from the source bank each
// cycle through its two read ports, one element per cycle. Results then leave
// one per cycle: strobe is high for exactly one cycle per sorted element, with
// sorted_value, final_res on the largest element, and overflow set on every
// result when elements were dropped. The receiver cannot stall; it must take
// each result in its strobe cycle. Busy falls in the cycle of the last result,
// and the next batch may start then. Reset clears the count, the drop flag
// and the sequencer; bank contents are only read after being written.
module merge_sort_engine_unit
    import mse_pkg::*;
#(
    parameter int MAX_ELEMS = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     last,
    output logic                     strobe,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     final_res,
    output logic                     overflow
);

    localparam int AW = (MAX_ELEMS > 1) ? $clog2(MAX_ELEMS) : 1;
    localparam int CW = $clog2(MAX_ELEMS + 1);
    localparam int WW = CW + 1;
    localparam int XW = CW + 2;

    mse_state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          dropped_reg, dropped_next;
    logic          sel_reg, sel_next;
    logic [WW-1:0] w_reg, w_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] j_reg, j_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic          strobe_reg, strobe_next;
    logic          final_reg, final_next;
    logic          ovf_reg, ovf_next;

    logic              load_we;
    logic              merge_we;
    logic              take_left;
    logic [XW-1:0]     mid_sum;
    logic [XW-1:0]     hi_sum;
    logic [CW-1:0]     mid_calc;
    logic [CW-1:0]     hi_calc;
    logic [AW-1:0]     rd_addr_a;
    logic [AW-1:0]     rd_addr_b;
    logic [DATA_W-1:0] a_rdata_a, a_rdata_b, b_rdata_a, b_rdata_b;
    logic [DATA_W-1:0] src_a, src_b;
    logic [DATA_W-1:0] merge_data;
    logic              a_we, b_we;
    logic [AW-1:0]     a_waddr;
    logic [DATA_W-1:0] a_wdata;

    // Heads of the current source bank.
    assign src_a = sel_reg ? b_rdata_a : a_rdata_a;
    assign src_b = sel_reg ? b_rdata_b : a_rdata_b;

    // Left head wins while it has elements and the right run is empty or not smaller.
    assign take_left = (i_reg < mid_reg) &&
                       ((j_reg >= hi_reg) || ($signed(src_a) <= $signed(src_b)));
    assign merge_data = take_left ? src_a : src_b;

    // Run boundaries for the run pair starting at k, clamped to the batch size.
    assign mid_sum  = XW'(k_reg) + XW'(w_reg);
    assign hi_sum   = XW'(k_reg) + (XW'(w_reg) << 1);
    assign mid_calc = (mid_sum > XW'(cnt_reg)) ? cnt_reg : mid_sum[CW-1:0];
    assign hi_calc  = (hi_sum > XW'(cnt_reg)) ? cnt_reg : hi_sum[CW-1:0];

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            dropped_reg <= 1'b0;
            sel_reg     <= 1'b0;
            w_reg       <= '0;
            k_reg       <= '0;
            i_reg       <= '0;
            j_reg       <= '0;
            mid_reg     <= '0;
            hi_reg      <= '0;
            strobe_reg  <= 1'b0;
            final_reg   <= 1'b0;
            ovf_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            dropped_reg <= dropped_next;
            sel_reg     <= sel_next;
            w_reg       <= w_next;
            k_reg       <= k_next;
            i_reg       <= i_next;
            j_reg       <= j_next;
            mid_reg     <= mid_next;
            hi_reg      <= hi_next;
            strobe_reg  <= strobe_next;
            final_reg   <= final_next;
            ovf_reg     <= ovf_next;
        end
    end

    // Sequencer: load, merge passes, readout.
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        dropped_next = dropped_reg;
        sel_next     = sel_reg;
        w_next       = w_reg;
        k_next       = k_reg;
        i_next       = i_reg;
        j_next       = j_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        strobe_next  = 1'b0;
        final_next   = 1'b0;
        ovf_next     = ovf_reg;
        load_we      = 1'b0;
        merge_we     = 1'b0;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (start)
                begin
                    if (cnt_reg < CW'(MAX_ELEMS))
                    begin
                        load_we  = 1'b1;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (last)
                    begin
                        state_next = ST_PASS;
                        w_next     = WW'(1);
                        k_next     = '0;
                        sel_next   = 1'b0;
                    end
                end
            end
            ST_PASS:
            begin
                // Runs as wide as the batch mean the source bank is sorted.
                k_next = '0;
                if (w_reg >= WW'(cnt_reg))
                begin
                    state_next = ST_OUT;
                end
                else
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (k_reg == cnt_reg)
                begin
                    sel_next   = !sel_reg;
                    w_next     = w_reg << 1;
                    state_next = ST_PASS;
                end
                else
                begin
                    i_next     = k_reg;
                    j_next     = mid_calc;
                    mid_next   = mid_calc;
                    hi_next    = hi_calc;
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                merge_we = 1'b1;
                k_next   = k_reg + 1'b1;
                if (take_left)
                begin
                    i_next = i_reg + 1'b1;
                end
                else
                begin
                    j_next = j_reg + 1'b1;
                end
                if (k_next == hi_reg)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_OUT:
            begin
                strobe_next = 1'b1;
                final_next  = (k_reg + 1'b1) == cnt_reg;
                ovf_next    = dropped_reg;
                k_next      = k_reg + 1'b1;
                if (final_next)
                begin
                    state_next   = ST_LOAD;
                    cnt_next     = '0;
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // Read addresses follow the next heads, or k in readout, so data is ready next cycle.
    assign rd_addr_a = (state_reg == ST_OUT) ? k_reg[AW-1:0] : i_next[AW-1:0];
    assign rd_addr_b = j_next[AW-1:0];

    // Bank A takes loads and merge writes when B is the source.
    assign a_we    = load_we || (merge_we && sel_reg);
    assign a_waddr = load_we ? cnt_reg[AW-1:0] : k_reg[AW-1:0];
    assign a_wdata = load_we ? value : merge_data;
    assign b_we    = merge_we && !sel_reg;

    mse_bank #(
        .DEPTH (MAX_ELEMS),
        .AW    (AW)
    ) u_bank_a (
        .clk     (clk),
        .we      (a_we),
        .waddr   (a_waddr),
        .wdata   (a_wdata),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (a_rdata_a),
        .rdata_b (a_rdata_b)
    );

    mse_bank #(
        .DEPTH (MAX_ELEMS),
        .AW    (AW)
    ) u_bank_b (
        .clk     (clk),
        .we      (b_we),
        .waddr   (k_reg[AW-1:0]),
        .wdata   (merge_data),
        .raddr_a (rd_addr_a),
        .raddr_b (rd_addr_b),
        .rdata_a (b_rdata_a),
        .rdata_b (b_rdata_b)
    );

    // Outputs.
    assign busy         = (state_reg != ST_LOAD);
    assign strobe       = strobe_reg;
    assign sorted_value = sel_reg ? b_rdata_a : a_rdata_a;
    assign final_res    = final_reg;
    assign overflow     = ovf_reg;

    // A result only follows a readout cycle.
    a_strobe_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg == ST_OUT))
        else $error("result strobe without readout");

    // The final flag only rides on a result.
    a_final_with_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        final_res |-> strobe)
        else $error("final flag without result");

    // Merge writes stay inside the batch.
    a_merge_in_batch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MERGE) |-> (k_reg < cnt_reg))
        else $error("merge write beyond batch");

    // The engine is free again when the last result goes out.
    a_idle_after_final: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && final_res) |-> !busy)
        else $error("engine busy after final result");

endmodule
